// ===== design/keyed_record_stream_parser_core_assert.svh =====
// Assertion macros for the keyed record stream parser.
// Each check is clocked on the rising edge and held off while reset is low.
`ifndef KEYED_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define KEYED_RECORD_STREAM_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH

// Condition must never hold.
`define KRSP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("krsp: forbidden condition seen");

// Antecedent implies the consequent in the same cycle.
`define KRSP_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("krsp: implication failed");

// Antecedent implies the consequent in the following cycle.
`define KRSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("krsp: next-cycle implication failed");

`else

`define KRSP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define KRSP_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define KRSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ===== design/krsp_pkg.sv =====
`default_nettype none

package krsp_pkg;

    // Key length bound and counter width (counter saturates at the bound)
    localparam int KEY_LIMIT = 512;
    localparam int KEY_CW    = $clog2(KEY_LIMIT + 1);

    // Printable key character range
    localparam logic [7:0] KEY_CHAR_MIN = 8'h21;
    localparam logic [7:0] KEY_CHAR_MAX = 8'h7E;

    // Result kinds
    localparam logic [1:0] KIND_RECORD  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ERR_KEY_OPEN  = 3'd2;
    localparam logic [2:0] ERR_KEY_EMPTY = 3'd3;
    localparam logic [2:0] ERR_SIZE_CUT  = 3'd4;
    localparam logic [2:0] ERR_VALUE_CUT = 3'd5;
    localparam logic [2:0] ERR_KEY_LONG  = 3'd6;

    // Values up to this size are passed out as they are
    localparam logic [31:0] INLINE_MAX = 32'd8;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Refused key prefixes
    localparam int PFX_IW   = 5;
    localparam int PFX0_LEN = 17;
    localparam int PFX1_LEN = 16;
    localparam int PFX2_LEN = 13;
    localparam int PFX3_LEN = 5;
    localparam logic [PFX0_LEN*8-1:0] PFX0_TEXT = "cart.coprocessor.";
    localparam logic [PFX1_LEN*8-1:0] PFX1_TEXT = "cart.bsxMemPack.";
    localparam logic [PFX2_LEN*8-1:0] PFX2_TEXT = "cart.gameboy.";
    localparam logic [PFX3_LEN*8-1:0] PFX3_TEXT = "msu1.";

    typedef enum logic [1:0] {
        PH_KEY,
        PH_SIZE,
        PH_VALUE,
        PH_DROP
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [23:0] record_number;
        logic [8:0]  key_length;
        logic [31:0] value_size;
        logic [63:0] value_or_check;
        logic        value_is_check;
        logic        record_refused;
        logic        stream_refused;
        logic [2:0]  error_code;
    } t_out_item;

    // One step of the parser: whether it gives a result, and the result
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_res;

    // Advance the CRC by one byte, one bit per iteration
    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Length of prefix k
    function automatic logic [PFX_IW-1:0] pfx_len(logic [1:0] k);
        logic [PFX_IW-1:0] len;
        case (k)
            2'd0:    len = PFX_IW'(PFX0_LEN);
            2'd1:    len = PFX_IW'(PFX1_LEN);
            2'd2:    len = PFX_IW'(PFX2_LEN);
            default: len = PFX_IW'(PFX3_LEN);
        endcase
        return len;
    endfunction

    // Key byte at position count keeps prefix k alive (past its end it always does)
    function automatic logic pfx_char_ok(logic [1:0] k, logic [KEY_CW-1:0] count,
                                         logic [7:0] data);
        logic [PFX_IW-1:0] idx;
        logic [7:0]        ch;
        idx = count[PFX_IW-1:0];
        case (k)
            2'd0:    ch = PFX0_TEXT[8*(PFX0_LEN-1-int'(idx)) +: 8];
            2'd1:    ch = PFX1_TEXT[8*(PFX1_LEN-1-int'(idx)) +: 8];
            2'd2:    ch = PFX2_TEXT[8*(PFX2_LEN-1-int'(idx)) +: 8];
            default: ch = PFX3_TEXT[8*(PFX3_LEN-1-int'(idx)) +: 8];
        endcase
        if ({1'b0, count} < (KEY_CW+1)'(pfx_len(k))) begin
            return ch == data;
        end
        return 1'b1;
    endfunction

    // Key of this length covers prefix k completely
    function automatic logic pfx_covered(logic [1:0] k, logic [KEY_CW-1:0] count);
        return {1'b0, count} >= (KEY_CW+1)'(pfx_len(k));
    endfunction

endpackage

`default_nettype wire

// ===== design/krsp_engine.sv =====
`default_nettype none

module krsp_engine (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_step,
    input  wire krsp_pkg::t_in_item  i_item,
    output krsp_pkg::t_step_res      o_res
);

    krsp_pkg::t_phase              r_phase, n_phase;
    logic [krsp_pkg::KEY_CW-1:0]   r_key_count, n_key_count;
    logic [1:0]                    r_size_cnt, n_size_cnt;
    logic [31:0]                   r_record_size, n_record_size;
    logic [31:0]                   r_bytes_left, n_bytes_left;
    logic [63:0]                   r_value_acc, n_value_acc;
    logic [31:0]                   r_crc, n_crc;
    logic [3:0]                    r_pfx_match, n_pfx_match;
    logic                          r_any_refused, n_any_refused;
    logic [23:0]                   r_records_done, n_records_done;

    logic        fin;
    logic [31:0] fin_size;
    logic [63:0] fin_val;
    logic        fin_chk;
    logic        rref;
    logic [31:0] size_new;
    logic [31:0] left_new;
    logic [2:0]  pos;
    logic [7:0]  b;

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= krsp_pkg::PH_KEY;
            r_key_count    <= '0;
            r_size_cnt     <= '0;
            r_record_size  <= '0;
            r_bytes_left   <= '0;
            r_value_acc    <= '0;
            r_crc          <= krsp_pkg::CRC_INIT;
            r_pfx_match    <= '1;
            r_any_refused  <= 1'b0;
            r_records_done <= '0;
        end else begin
            r_phase        <= n_phase;
            r_key_count    <= n_key_count;
            r_size_cnt     <= n_size_cnt;
            r_record_size  <= n_record_size;
            r_bytes_left   <= n_bytes_left;
            r_value_acc    <= n_value_acc;
            r_crc          <= n_crc;
            r_pfx_match    <= n_pfx_match;
            r_any_refused  <= n_any_refused;
            r_records_done <= n_records_done;
        end
    end

    // Decode one request, advance state and form the result
    always_comb begin
        n_phase        = r_phase;
        n_key_count    = r_key_count;
        n_size_cnt     = r_size_cnt;
        n_record_size  = r_record_size;
        n_bytes_left   = r_bytes_left;
        n_value_acc    = r_value_acc;
        n_crc          = r_crc;
        n_pfx_match    = r_pfx_match;
        n_any_refused  = r_any_refused;
        n_records_done = r_records_done;

        b        = i_item.payload_byte;
        fin      = 1'b0;
        fin_size = r_record_size;
        fin_val  = '0;
        fin_chk  = 1'b0;
        size_new = r_record_size | (32'(b) << {r_size_cnt, 3'b000});
        left_new = r_bytes_left - 32'd1;
        pos      = r_record_size[2:0] - r_bytes_left[2:0];

        // Refused when a still-matching prefix is fully covered by the key
        rref = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (r_pfx_match[k] && krsp_pkg::pfx_covered(2'(k), r_key_count)) begin
                rref = 1'b1;
            end
        end

        o_res                    = '0;
        o_res.item.record_number = r_records_done;
        o_res.item.stream_refused = r_any_refused;

        if (i_step) begin
            if (i_item.action) begin
                // End marker: report the open state (nothing while dropping), then start a new stream
                if (r_phase == krsp_pkg::PH_KEY && r_key_count == '0) begin
                    o_res.valid          = 1'b1;
                    o_res.item.item_kind = krsp_pkg::KIND_SUMMARY;
                end else if (r_phase == krsp_pkg::PH_KEY) begin
                    o_res.valid           = 1'b1;
                    o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                    o_res.item.error_code = krsp_pkg::ERR_KEY_OPEN;
                end else if (r_phase == krsp_pkg::PH_SIZE) begin
                    o_res.valid           = 1'b1;
                    o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                    o_res.item.error_code = krsp_pkg::ERR_SIZE_CUT;
                end else if (r_phase == krsp_pkg::PH_VALUE) begin
                    o_res.valid           = 1'b1;
                    o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                    o_res.item.error_code = krsp_pkg::ERR_VALUE_CUT;
                end
                n_phase        = krsp_pkg::PH_KEY;
                n_key_count    = '0;
                n_size_cnt     = '0;
                n_record_size  = '0;
                n_bytes_left   = '0;
                n_value_acc    = '0;
                n_crc          = krsp_pkg::CRC_INIT;
                n_pfx_match    = '1;
                n_any_refused  = 1'b0;
                n_records_done = '0;
            end else begin
                case (r_phase)
                    krsp_pkg::PH_KEY: begin
                        if (b == 8'h00) begin
                            if (r_key_count == '0) begin
                                o_res.valid           = 1'b1;
                                o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                                o_res.item.error_code = krsp_pkg::ERR_KEY_EMPTY;
                                n_phase               = krsp_pkg::PH_DROP;
                            end else begin
                                n_phase       = krsp_pkg::PH_SIZE;
                                n_size_cnt    = '0;
                                n_record_size = '0;
                            end
                        end else if (!(b inside {[krsp_pkg::KEY_CHAR_MIN :
                                                  krsp_pkg::KEY_CHAR_MAX]})) begin
                            o_res.valid           = 1'b1;
                            o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                            o_res.item.error_code = krsp_pkg::ERR_BAD_CHAR;
                            n_phase               = krsp_pkg::PH_DROP;
                        end else begin
                            // Drop prefixes that this byte breaks
                            for (int k = 0; k < 4; k++) begin
                                if (!krsp_pkg::pfx_char_ok(2'(k), r_key_count, b)) begin
                                    n_pfx_match[k] = 1'b0;
                                end
                            end
                            if (r_key_count < krsp_pkg::KEY_CW'(krsp_pkg::KEY_LIMIT)) begin
                                n_key_count = r_key_count + krsp_pkg::KEY_CW'(1);
                            end
                        end
                    end
                    krsp_pkg::PH_SIZE: begin
                        n_record_size = size_new;
                        n_size_cnt    = r_size_cnt + 2'd1;
                        if (r_size_cnt == 2'd3) begin
                            n_size_cnt   = '0;
                            n_value_acc  = '0;
                            n_crc        = krsp_pkg::CRC_INIT;
                            n_bytes_left = size_new;
                            if (size_new == '0) begin
                                fin      = 1'b1;
                                fin_size = '0;
                            end else begin
                                n_phase = krsp_pkg::PH_VALUE;
                            end
                        end
                    end
                    krsp_pkg::PH_VALUE: begin
                        if (r_record_size <= krsp_pkg::INLINE_MAX) begin
                            // Place the byte at its little-endian lane
                            for (int i = 0; i < 8; i++) begin
                                if (pos == 3'(i)) begin
                                    n_value_acc[8*i +: 8] = r_value_acc[8*i +: 8] | b;
                                end
                            end
                        end else begin
                            n_crc = krsp_pkg::crc32_byte(r_crc, b);
                        end
                        n_bytes_left = left_new;
                        if (left_new == '0) begin
                            fin = 1'b1;
                            if (r_record_size <= krsp_pkg::INLINE_MAX) begin
                                fin_val = n_value_acc;
                            end else begin
                                fin_val = {32'd0, ~n_crc};
                                fin_chk = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Drop bytes until the end marker
                    end
                endcase

                // Close the record
                if (fin) begin
                    o_res.valid = 1'b1;
                    if (r_key_count == krsp_pkg::KEY_CW'(krsp_pkg::KEY_LIMIT)) begin
                        o_res.item.item_kind  = krsp_pkg::KIND_ERROR;
                        o_res.item.error_code = krsp_pkg::ERR_KEY_LONG;
                        n_phase               = krsp_pkg::PH_DROP;
                    end else begin
                        o_res.item.item_kind      = krsp_pkg::KIND_RECORD;
                        o_res.item.key_length     = 9'(r_key_count);
                        o_res.item.value_size     = fin_size;
                        o_res.item.value_or_check = fin_val;
                        o_res.item.value_is_check = fin_chk;
                        o_res.item.record_refused = rref;
                        o_res.item.stream_refused = r_any_refused | rref;
                        n_any_refused  = r_any_refused | rref;
                        n_records_done = r_records_done + 24'd1;
                        n_phase        = krsp_pkg::PH_KEY;
                        n_key_count    = '0;
                        n_size_cnt     = '0;
                        n_record_size  = '0;
                        n_bytes_left   = '0;
                        n_value_acc    = '0;
                        n_crc          = krsp_pkg::CRC_INIT;
                        n_pfx_match    = '1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/keyed_record_stream_parser_core.sv =====
// Keyed record stream parser: one payload byte or end marker per request.
// A result passes through the input register, the combinational step and the output register.
// Throughput: one request per cycle from the combinational step between the two
// registers; a stalled result holds the step and, once the input register is full, input.
// Reset (i_rst_n low at a rising edge) empties both registers and returns the
// parser to the start of a stream with no records counted.
`default_nettype none

`include "keyed_record_stream_parser_core_assert.svh"

module keyed_record_stream_parser_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire krsp_pkg::t_in_item  i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output krsp_pkg::t_out_item      o_out_data,
    input  wire                      i_out_stall
);

    logic                r_in_valid;
    krsp_pkg::t_in_item  r_in;
    logic                r_out_valid;
    krsp_pkg::t_out_item r_out;

    logic                in_take;
    logic                step;
    krsp_pkg::t_step_res res;

    logic                out_error;
    logic                out_record;
    logic                out_has_code;
    logic                out_refuse_ok;

    // Advance a request when the output register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // Hold the taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    krsp_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Classify the offered result for the checks
    assign out_error     = o_out_valid && o_out_data.item_kind == krsp_pkg::KIND_ERROR;
    assign out_record    = o_out_valid && o_out_data.item_kind == krsp_pkg::KIND_RECORD;
    assign out_has_code  = o_out_data.error_code != krsp_pkg::ERR_NONE;
    assign out_refuse_ok = o_out_data.stream_refused || !o_out_data.record_refused;

    // Checks
    `KRSP_ASSERT_NEVER(a_stall_needs_item, i_clk, i_rst_n, o_in_stall && !r_in_valid)
    `KRSP_ASSERT_IMPLY(a_error_has_code, i_clk, i_rst_n, out_error, out_has_code)
    `KRSP_ASSERT_IMPLY(a_record_clean, i_clk, i_rst_n, out_record, !out_has_code && out_refuse_ok)
    `KRSP_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, step && res.valid, o_out_valid)

endmodule

`default_nettype wire
